>>> design/assert_macros.svh
// assertion helpers used by the matcher unit
// each macro expects clk_i and rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define PTO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define PTO_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

`endif

>>> design/pto_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pto_pkg
// Types and constants for the price/time priority order matcher.
// ---------------------------------------------------------------------------
package pto_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int PRICE_W     = 32;
  localparam int QTY_W       = 24;
  localparam int ID_W        = 32;
  localparam int SEQ_W       = 32;
  localparam int SUM_W       = 64;
  localparam int PROD_W      = PRICE_W + QTY_W;
  localparam int DIV_CNT_W   = $clog2(SUM_W);

  typedef enum logic [1:0] {
    OP_PLACE  = 2'd0,
    OP_MARKET = 2'd1,
    OP_CANCEL = 2'd2,
    OP_MODIFY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_INVALID   = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic {
    SIDE_BUY  = 1'b0,
    SIDE_SELL = 1'b1
  } side_e;

  typedef enum logic {
    KIND_TRADE   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_BEST,
    S_SCAN_ID,
    S_FILL,
    S_ACC,
    S_POST,
    S_DIV,
    S_SUMMARY
  } fsm_e;

  // one resting order as stored in the table memory
  typedef struct packed {
    side_e                side;
    logic [PRICE_W-1:0]   price;
    logic [QTY_W-1:0]     remaining;
    logic [SEQ_W-1:0]     seq;
    logic [ID_W-1:0]      id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> design/pto_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pto_ram
// Generic single write, single read RAM with a registered read.
// ---------------------------------------------------------------------------
module pto_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/price_time_order_matcher_unit.sv
`timescale 1ns / 1ps
// The block takes one operation at a time and holds in_stall_o high until the
// summary of that operation has been loaded into the output register. Every
// lookup walks the order table through the single read port of the table RAM.
// A cancel runs one scan to find its order. A place, market or modify runs one
// scan for every fill plus one final scan when quantity is still left (a modify
// first spends one more scan to find its order), and each fill passes through
// the fill and accumulate states. When anything executed, a bit-serial division
// for the average price follows; waits on out_stall_i hold the fill and summary
// states.
// ---------------------------------------------------------------------------
// price_time_order_matcher_unit
// Limit order book matcher with price/time priority over a RAM-held table.
// ---------------------------------------------------------------------------
module price_time_order_matcher_unit
  import pto_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic               side_i,
  input  logic [PRICE_W-1:0] price_i,
  input  logic [QTY_W-1:0]   quantity_i,
  input  logic [ID_W-1:0]    target_id_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic               last_o,
  output logic [1:0]         status_o,
  output logic [ID_W-1:0]    id_out_o,
  output logic [PRICE_W-1:0] trade_price_o,
  output logic [QTY_W-1:0]   amount_o,
  output logic [QTY_W-1:0]   left_over_o,
  output logic [PRICE_W-1:0] mean_price_o,
  output logic               ok_flag_o
);

`include "assert_macros.svh"

  // control state
  fsm_e                   state_q, state_d;
  logic                   out_valid_q, out_valid_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [ID_W-1:0]        next_id_q, next_id_d;
  logic [SEQ_W-1:0]       next_seq_q, next_seq_d;
  logic [CNT_W-1:0]       scan_cnt_q, scan_cnt_d;
  logic                   cmp_vld_q, cmp_vld_d;
  logic                   found_q, found_d;

  // operation payload
  op_e                    op_q, op_d;
  side_e                  side_q, side_d;
  logic [PRICE_W-1:0]     price_q, price_d;
  logic [QTY_W-1:0]       rem_q, rem_d;
  logic [ID_W-1:0]        target_q, target_d;
  logic [ID_W-1:0]        id_q, id_d;
  logic [SEQ_W-1:0]       seq_q, seq_d;
  logic [ID_W-1:0]        sum_id_q, sum_id_d;
  status_e                status_q, status_d;
  logic                   ok_q, ok_d;
  logic [QTY_W-1:0]       exec_q, exec_d;
  logic [SUM_W-1:0]       wsum_q, wsum_d;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic [QTY_W-1:0]       rmd_q, rmd_d;
  logic [DIV_CNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic [IDX_W-1:0]       cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]       best_idx_q, best_idx_d;
  logic [IDX_W-1:0]       slot_q, slot_d;
  entry_t                 best_q, best_d;

  // output register
  kind_e                  o_kind_q, o_kind_d;
  status_e                o_status_q, o_status_d;
  logic [ID_W-1:0]        o_id_q, o_id_d;
  logic [PRICE_W-1:0]     o_tprice_q, o_tprice_d;
  logic [QTY_W-1:0]       o_amount_q, o_amount_d;
  logic [QTY_W-1:0]       o_left_q, o_left_d;
  logic [PRICE_W-1:0]     o_avg_q, o_avg_d;
  logic                   o_ok_q, o_ok_d;

  // table memory
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  entry_t                 ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;
  entry_t                 rd;

  pto_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd = entry_t'(ram_rdata);

  // candidate evaluation on the entry returned by the scan
  logic             rd_live;
  logic             price_ok;
  logic             price_better;
  logic             best_hit;
  logic             id_hit;
  logic             scan_done;
  logic             out_free;
  logic             in_accept;
  logic [QTY_W-1:0] fill;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [QTY_W:0]   trial;
  logic             qbit;
  logic [SUM_W-1:0] wsum_shift;

  assign rd_live      = cmp_vld_q && valid_q[cmp_idx_q];
  assign price_ok     = (op_q == OP_MARKET) ||
                        ((side_q == SIDE_BUY) ? (rd.price <= price_q) : (rd.price >= price_q));
  assign price_better = (side_q == SIDE_BUY) ? (rd.price < best_q.price)
                                             : (rd.price > best_q.price);
  assign best_hit     = rd_live && (rd.side != side_q) && price_ok &&
                        (!found_q || price_better ||
                         ((rd.price == best_q.price) && (rd.seq < best_q.seq)));
  assign id_hit       = rd_live && !found_q && (rd.id == target_q);
  assign scan_done    = (scan_cnt_q == CNT_W'(TABLE_DEPTH)) && !cmp_vld_q;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign in_accept    = in_valid_i && !in_stall_o;
  assign fill         = (rem_q < best_q.remaining) ? rem_q : best_q.remaining;

  // restoring divider step
  assign trial      = {rmd_q, wsum_q[SUM_W-1]};
  assign qbit       = (trial >= {1'b0, exec_q});
  assign wsum_shift = {wsum_q[SUM_W-2:0], qbit};

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // next state and datapath
  always_comb begin
    state_d    = state_q;
    out_valid_d = out_valid_q;
    valid_d    = valid_q;
    next_id_d  = next_id_q;
    next_seq_d = next_seq_q;
    scan_cnt_d = scan_cnt_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = scan_cnt_q[IDX_W-1:0];
    found_d    = found_q;
    op_d       = op_q;
    side_d     = side_q;
    price_d    = price_q;
    rem_d      = rem_q;
    target_d   = target_q;
    id_d       = id_q;
    seq_d      = seq_q;
    sum_id_d   = sum_id_q;
    status_d   = status_q;
    ok_d       = ok_q;
    exec_d     = exec_q;
    wsum_d     = wsum_q;
    prod_d     = prod_q;
    rmd_d      = rmd_q;
    div_cnt_d  = div_cnt_q;
    best_idx_d = best_idx_q;
    slot_d     = slot_q;
    best_d     = best_q;
    o_kind_d   = o_kind_q;
    o_status_d = o_status_q;
    o_id_d     = o_id_q;
    o_tprice_d = o_tprice_q;
    o_amount_d = o_amount_q;
    o_left_d   = o_left_q;
    o_avg_d    = o_avg_q;
    o_ok_d     = o_ok_q;
    ram_we     = 1'b0;
    ram_waddr  = best_idx_q;
    ram_wdata  = best_q;
    ram_raddr  = scan_cnt_q[IDX_W-1:0];

    // output transaction taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // table walk, one read issued per cycle
    if ((state_q == S_SCAN_BEST) || (state_q == S_SCAN_ID)) begin
      if (scan_cnt_q != CNT_W'(TABLE_DEPTH)) begin
        scan_cnt_d = scan_cnt_q + CNT_W'(1);
        cmp_vld_d  = 1'b1;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_d     = op_e'(operation_i);
          side_d   = side_e'(side_i);
          price_d  = price_i;
          rem_d    = quantity_i;
          target_d = target_id_i;
          exec_d   = '0;
          wsum_d   = '0;
          ok_d     = 1'b0;
          status_d = STAT_OK;
          sum_id_d = '0;
          scan_cnt_d = '0;
          found_d  = 1'b0;
          unique case (op_e'(operation_i))
            OP_PLACE: begin
              if ((price_i == '0) || (quantity_i == '0)) begin
                status_d = STAT_INVALID;
                state_d  = S_SUMMARY;
              end else begin
                id_d       = next_id_q;
                sum_id_d   = next_id_q;
                next_id_d  = next_id_q + ID_W'(1);
                seq_d      = next_seq_q;
                next_seq_d = next_seq_q + SEQ_W'(1);
                state_d    = S_SCAN_BEST;
              end
            end
            OP_MARKET: begin
              if (quantity_i == '0) begin
                status_d = STAT_INVALID;
                rem_d    = '0;
                state_d  = S_SUMMARY;
              end else begin
                state_d = S_SCAN_BEST;
              end
            end
            OP_CANCEL: begin
              sum_id_d = target_id_i;
              state_d  = S_SCAN_ID;
            end
            OP_MODIFY: begin
              sum_id_d = target_id_i;
              if ((price_i == '0) || (quantity_i == '0)) begin
                status_d = STAT_INVALID;
                rem_d    = '0;
                state_d  = S_SUMMARY;
              end else begin
                state_d = S_SCAN_ID;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_SCAN_BEST: begin
        if (best_hit) begin
          found_d    = 1'b1;
          best_d     = rd;
          best_idx_d = cmp_idx_q;
        end
        if (scan_done) begin
          state_d = found_q ? S_FILL : S_POST;
        end
      end

      S_SCAN_ID: begin
        if (id_hit) begin
          found_d    = 1'b1;
          best_d     = rd;
          best_idx_d = cmp_idx_q;
        end
        if (scan_done) begin
          if (!found_q) begin
            status_d = STAT_NOT_FOUND;
            rem_d    = '0;
            state_d  = S_SUMMARY;
          end else if (op_q == OP_CANCEL) begin
            valid_d[best_idx_q] = 1'b0;
            rem_d   = best_q.remaining;
            ok_d    = 1'b1;
            state_d = S_SUMMARY;
          end else begin
            // modify: pull the order out and match it again
            valid_d[best_idx_q] = 1'b0;
            side_d = best_q.side;
            slot_d = best_idx_q;
            ok_d   = 1'b1;
            if ((price_q != best_q.price) || (rem_q > best_q.remaining)) begin
              seq_d      = next_seq_q;
              next_seq_d = next_seq_q + SEQ_W'(1);
            end else begin
              seq_d = best_q.seq;
            end
            scan_cnt_d = '0;
            found_d    = 1'b0;
            state_d    = S_SCAN_BEST;
          end
        end
      end

      S_FILL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_kind_d    = KIND_TRADE;
          o_status_d  = STAT_OK;
          o_id_d      = best_q.id;
          o_tprice_d  = best_q.price;
          o_amount_d  = fill;
          o_left_d    = '0;
          o_avg_d     = '0;
          o_ok_d      = 1'b0;
          prod_d      = PROD_W'(best_q.price) * PROD_W'(fill);
          rem_d       = rem_q - fill;
          exec_d      = exec_q + fill;
          ram_we      = 1'b1;
          ram_waddr   = best_idx_q;
          ram_wdata   = best_q;
          ram_wdata.remaining = best_q.remaining - fill;
          if (best_q.remaining == fill) begin
            valid_d[best_idx_q] = 1'b0;
          end
          state_d = S_ACC;
        end
      end

      S_ACC: begin
        wsum_d = wsum_q + SUM_W'(prod_q);
        if (rem_q != '0) begin
          scan_cnt_d = '0;
          found_d    = 1'b0;
          state_d    = S_SCAN_BEST;
        end else begin
          state_d = S_POST;
        end
      end

      S_POST: begin
        // rest any remainder of a place or modify
        if (rem_q != '0) begin
          if (op_q == OP_PLACE) begin
            if (free_found) begin
              ram_we    = 1'b1;
              ram_waddr = free_idx;
              ram_wdata = '{side: side_q, price: price_q, remaining: rem_q,
                            seq: seq_q, id: id_q};
              valid_d[free_idx] = 1'b1;
            end else begin
              status_d = STAT_FULL;
            end
          end else if (op_q == OP_MODIFY) begin
            ram_we    = 1'b1;
            ram_waddr = slot_q;
            ram_wdata = '{side: side_q, price: price_q, remaining: rem_q,
                          seq: seq_q, id: target_q};
            valid_d[slot_q] = 1'b1;
          end
        end
        rmd_d     = '0;
        div_cnt_d = '0;
        state_d   = (exec_q != '0) ? S_DIV : S_SUMMARY;
      end

      S_DIV: begin
        rmd_d     = qbit ? QTY_W'(trial - {1'b0, exec_q}) : trial[QTY_W-1:0];
        wsum_d    = wsum_shift;
        div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
        if (div_cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
          state_d = S_SUMMARY;
        end
      end

      S_SUMMARY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_kind_d    = KIND_SUMMARY;
          o_status_d  = status_q;
          o_id_d      = sum_id_q;
          o_tprice_d  = '0;
          o_amount_d  = exec_q;
          o_left_d    = rem_q;
          o_avg_d     = (exec_q != '0) ? wsum_q[PRICE_W-1:0] : '0;
          o_ok_d      = ok_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      next_id_q   <= ID_W'(1);
      next_seq_q  <= '0;
      scan_cnt_q  <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      valid_q     <= valid_d;
      next_id_q   <= next_id_d;
      next_seq_q  <= next_seq_d;
      scan_cnt_q  <= scan_cnt_d;
      cmp_vld_q   <= cmp_vld_d;
      found_q     <= found_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    side_q     <= side_d;
    price_q    <= price_d;
    rem_q      <= rem_d;
    target_q   <= target_d;
    id_q       <= id_d;
    seq_q      <= seq_d;
    sum_id_q   <= sum_id_d;
    status_q   <= status_d;
    ok_q       <= ok_d;
    exec_q     <= exec_d;
    wsum_q     <= wsum_d;
    prod_q     <= prod_d;
    rmd_q      <= rmd_d;
    div_cnt_q  <= div_cnt_d;
    cmp_idx_q  <= cmp_idx_d;
    best_idx_q <= best_idx_d;
    slot_q     <= slot_d;
    best_q     <= best_d;
    o_kind_q   <= o_kind_d;
    o_status_q <= o_status_d;
    o_id_q     <= o_id_d;
    o_tprice_q <= o_tprice_d;
    o_amount_q <= o_amount_d;
    o_left_q   <= o_left_d;
    o_avg_q    <= o_avg_d;
    o_ok_q     <= o_ok_d;
  end

  // ports
  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign kind_o          = o_kind_q;
  assign last_o          = o_kind_q;
  assign status_o        = o_status_q;
  assign id_out_o        = o_id_q;
  assign trade_price_o   = o_tprice_q;
  assign amount_o        = o_amount_q;
  assign left_over_o     = o_left_q;
  assign mean_price_o    = o_avg_q;
  assign ok_flag_o       = o_ok_q;

  // checks
  `PTO_ASSERT_IMP(a_trade_nonzero, out_valid_o && (kind_o == KIND_TRADE), (amount_o != '0) && (status_o == STAT_OK), "trade with zero amount or bad status")
  `PTO_ASSERT_IMP(a_div_has_divisor, state_q == S_DIV, exec_q != '0, "division entered with nothing executed")
  `PTO_ASSERT_IMP(a_invalid_no_exec, out_valid_o && (kind_o == KIND_SUMMARY) && (status_o == STAT_INVALID), amount_o == '0, "invalid operation reported executions")
  `PTO_ASSERT(a_accept_busy, (in_valid_i && !in_stall_o) |=> in_stall_o, "operation accepted without going busy")

endmodule

>>> tb/price_time_order_matcher_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// price_time_order_matcher_unit_tb
// Drives place, market, cancel and modify transactions into the matcher.
// A local order book predicts every trade and summary. A monitor compares
// each accepted result field by field, in order.
// ---------------------------------------------------------------------------
module price_time_order_matcher_unit_tb;
  import pto_pkg::*;

  localparam int LIMIT_CYCLES = 5000000;
  localparam int PAUSE_AT     = 300;
  localparam int HOLD_AT      = 220;
  localparam int HOLD_CYCLES  = 600;
  localparam int N_RANDOM     = 420;

  typedef struct {
    op_e         op;
    logic        side;
    logic [31:0] price;
    logic [23:0] qty;
    logic [31:0] tgt;
  } order_t;

  typedef struct {
    kind_e       kind;
    logic        last;
    status_e     status;
    logic [31:0] id;
    logic [31:0] tprice;
    logic [23:0] amount;
    logic [23:0] left;
    logic [31:0] avg;
    logic        ok;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic kind_o, last_o, ok_flag_o;
  logic [1:0] status_o;
  logic [31:0] id_out_o, trade_price_o, mean_price_o;
  logic [23:0] amount_o, left_over_o;
  order_t cur = '{OP_PLACE, 1'b0, '0, '0, '0};

  order_t  pending_orders[$];
  report_t expected_reports[$];
  int      offer_idx = 0;
  int      n_accepted = 0;
  int      n_results = 0;
  int      n_trades = 0;
  int      n_full = 0;
  int      errors = 0;
  int      cycles = 0;
  int      hold_cnt = 0;
  bit      hold_done = 1'b0;

  // book mirror
  bit          bk_valid[TABLE_DEPTH];
  logic        bk_side[TABLE_DEPTH];
  logic [31:0] bk_price[TABLE_DEPTH];
  logic [23:0] bk_rem[TABLE_DEPTH];
  logic [31:0] bk_seq[TABLE_DEPTH];
  logic [31:0] bk_id[TABLE_DEPTH];
  logic [31:0] next_oid = 32'd1;
  logic [31:0] next_seqn = 32'd0;
  logic [63:0] wsum;
  logic [23:0] exec_qty;

  price_time_order_matcher_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .operation_i(cur.op), .side_i(cur.side), .price_i(cur.price),
    .quantity_i(cur.qty), .target_id_i(cur.tgt),
    .out_valid_o, .out_stall_i, .kind_o, .last_o, .status_o, .id_out_o,
    .trade_price_o, .amount_o, .left_over_o, .mean_price_o, .ok_flag_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_order(order_t o);
    pending_orders.insert(pending_orders.size(), o);
  endfunction

  function automatic void push_report(kind_e k, status_e s, logic [31:0] id,
                                      logic [31:0] tp, logic [23:0] amt,
                                      logic [23:0] left, logic [31:0] avg,
                                      logic ok);
    expected_reports.insert(expected_reports.size(),
                            '{k, k == KIND_SUMMARY, s, id, tp, amt, left, avg, ok});
  endfunction

  function automatic logic [31:0] avg_price();
    logic [63:0] q;
    if (exec_qty == '0) return '0;
    q = wsum / {40'd0, exec_qty};
    return q[31:0];
  endfunction

  // best crossing counter order: best price, then earliest sequence
  function automatic int best_slot(logic s, bit limited, logic [31:0] lim);
    int b;
    logic [31:0] p;
    b = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!bk_valid[i] || bk_side[i] == s) continue;
      p = bk_price[i];
      if (limited && (s == SIDE_BUY ? p > lim : p < lim)) continue;
      if (b < 0) b = i;
      else if ((s == SIDE_BUY ? p < bk_price[b] : p > bk_price[b]) ||
               (p == bk_price[b] && bk_seq[i] < bk_seq[b])) b = i;
    end
    return b;
  endfunction

  // fill against the book until done or nothing crosses
  function automatic logic [23:0] fill_book(logic s, bit limited, logic [31:0] lim,
                                            logic [23:0] qty);
    logic [23:0] rem, q;
    int b;
    rem = qty;
    while (rem != 0) begin
      b = best_slot(s, limited, lim);
      if (b < 0) break;
      q = rem < bk_rem[b] ? rem : bk_rem[b];
      push_report(KIND_TRADE, STAT_OK, bk_id[b], bk_price[b], q, '0, '0, 1'b0);
      wsum += {32'd0, bk_price[b]} * {40'd0, q};
      exec_qty += q;
      rem -= q;
      bk_rem[b] -= q;
      if (bk_rem[b] == 0) bk_valid[b] = 1'b0;
    end
    return rem;
  endfunction

  function automatic int slot_of(logic [31:0] id);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (bk_valid[i] && bk_id[i] == id) return i;
    return -1;
  endfunction

  // expected results of one accepted transaction
  function automatic void predict_order(order_t o);
    logic [31:0] id, sq;
    logic [23:0] rem;
    logic        os;
    int          s;
    wsum = '0;
    exec_qty = '0;
    case (o.op)
      OP_PLACE: begin
        if (o.price == 0 || o.qty == 0) begin
          push_report(KIND_SUMMARY, STAT_INVALID, '0, '0, '0, o.qty, '0, 1'b0);
          return;
        end
        id = next_oid;
        next_oid++;
        sq = next_seqn;
        next_seqn++;
        rem = fill_book(o.side, 1'b1, o.price, o.qty);
        if (rem != 0) begin
          s = -1;
          for (int i = 0; i < TABLE_DEPTH && s < 0; i++)
            if (!bk_valid[i]) s = i;
          if (s < 0) begin
            push_report(KIND_SUMMARY, STAT_FULL, id, '0, exec_qty, rem, avg_price(), 1'b0);
            return;
          end
          bk_valid[s] = 1'b1;
          bk_side[s] = o.side;
          bk_price[s] = o.price;
          bk_rem[s] = rem;
          bk_seq[s] = sq;
          bk_id[s] = id;
        end
        push_report(KIND_SUMMARY, STAT_OK, id, '0, exec_qty, rem, avg_price(), 1'b0);
      end
      OP_MARKET: begin
        if (o.qty == 0) begin
          push_report(KIND_SUMMARY, STAT_INVALID, '0, '0, '0, '0, '0, 1'b0);
          return;
        end
        rem = fill_book(o.side, 1'b0, '0, o.qty);
        push_report(KIND_SUMMARY, STAT_OK, '0, '0, exec_qty, rem, avg_price(), 1'b0);
      end
      OP_CANCEL: begin
        s = slot_of(o.tgt);
        if (s < 0) begin
          push_report(KIND_SUMMARY, STAT_NOT_FOUND, o.tgt, '0, '0, '0, '0, 1'b0);
          return;
        end
        bk_valid[s] = 1'b0;
        push_report(KIND_SUMMARY, STAT_OK, o.tgt, '0, '0, bk_rem[s], '0, 1'b1);
      end
      default: begin
        if (o.price == 0 || o.qty == 0) begin
          push_report(KIND_SUMMARY, STAT_INVALID, o.tgt, '0, '0, '0, '0, 1'b0);
          return;
        end
        s = slot_of(o.tgt);
        if (s < 0) begin
          push_report(KIND_SUMMARY, STAT_NOT_FOUND, o.tgt, '0, '0, '0, '0, 1'b0);
          return;
        end
        os = bk_side[s];
        sq = bk_seq[s];
        if (o.price != bk_price[s] || o.qty > bk_rem[s]) begin
          sq = next_seqn;
          next_seqn++;
        end
        bk_valid[s] = 1'b0;
        rem = fill_book(os, 1'b1, o.price, o.qty);
        if (rem != 0) begin
          bk_valid[s] = 1'b1;
          bk_price[s] = o.price;
          bk_rem[s] = rem;
          bk_seq[s] = sq;
        end
        push_report(KIND_SUMMARY, STAT_OK, o.tgt, '0, exec_qty, rem, avg_price(), 1'b1);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
    $display("mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got, exp);
    errors++;
  endtask

  // sender: offers queued transactions, predicts on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_order(cur);
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (offer_idx < pending_orders.size() &&
            !(offer_idx == PAUSE_AT && expected_reports.size() != 0) &&
            ((offer_idx >= 100 && offer_idx < 180) || $urandom_range(99) >= 22)) begin
          cur <= pending_orders[offer_idx];
          offer_idx++;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (n_accepted >= 100 && n_accepted < 180) ? 1'b0
                     : ($urandom_range(99) < 22);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    report_t e;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (kind_o == KIND_TRADE) n_trades++;
      if (status_o == STAT_FULL) n_full++;
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected result", 64'(id_out_o), '0);
      end else begin
        e = expected_reports.pop_front();
        if (kind_o !== e.kind) report_mismatch("kind", 64'(kind_o), 64'(e.kind));
        if (last_o !== e.last) report_mismatch("last", 64'(last_o), 64'(e.last));
        if (status_o !== e.status)
          report_mismatch("status", 64'(status_o), 64'(e.status));
        if (id_out_o !== e.id) report_mismatch("id_out", 64'(id_out_o), 64'(e.id));
        if (trade_price_o !== e.tprice)
          report_mismatch("trade_price", 64'(trade_price_o), 64'(e.tprice));
        if (amount_o !== e.amount)
          report_mismatch("amount", 64'(amount_o), 64'(e.amount));
        if (left_over_o !== e.left)
          report_mismatch("left_over", 64'(left_over_o), 64'(e.left));
        if (mean_price_o !== e.avg)
          report_mismatch("mean_price", 64'(mean_price_o), 64'(e.avg));
        if (ok_flag_o !== e.ok) report_mismatch("ok_flag", 64'(ok_flag_o), 64'(e.ok));
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [31:0] gen_oid;
    logic [31:0] pr;
    logic [23:0] qt;
    logic        sd;
    int          pick;
    op_e         op;
    gen_oid = 32'd1;

    // directed: invalid inputs, empty book, unknown ids, field extremes
    add_order('{OP_PLACE, SIDE_BUY, 32'd100, 24'd0, '0});
    add_order('{OP_PLACE, SIDE_SELL, 32'd0, 24'd5, '0});
    add_order('{OP_MARKET, SIDE_BUY, 32'd7, 24'd0, '0});
    add_order('{OP_MARKET, SIDE_SELL, '1, 24'd9, '1});
    add_order('{OP_CANCEL, SIDE_BUY, '0, '0, 32'hFFFF_FFFF});
    add_order('{OP_MODIFY, SIDE_BUY, 32'd0, 24'd3, 32'd1});
    add_order('{OP_MODIFY, SIDE_SELL, 32'd5, 24'd3, 32'd77});
    add_order('{OP_PLACE, SIDE_SELL, '1, '1, '0});
    add_order('{OP_PLACE, SIDE_BUY, '1, 24'd5, '0});
    add_order('{OP_PLACE, SIDE_BUY, 32'd1, 24'd10, '0});
    add_order('{OP_PLACE, SIDE_SELL, 32'd1, 24'd3, '0});
    add_order('{OP_CANCEL, SIDE_SELL, '1, '1, 32'd3});
    add_order('{OP_MODIFY, SIDE_BUY, 32'hFFFF_FFFE, 24'hFFFFF0, 32'd1});
    add_order('{OP_MODIFY, SIDE_BUY, 32'hFFFF_FFFE, 24'hFFFF00, 32'd1});
    add_order('{OP_MARKET, SIDE_BUY, '0, '1, '0});
    gen_oid = 32'd5;

    // fill the table with resting bids, overflow it, then sweep it
    for (int i = 0; i < 34; i++) begin
      add_order('{OP_PLACE, SIDE_BUY, 32'($urandom_range(40, 1)),
                  24'($urandom_range(9, 1)), '0});
      gen_oid++;
    end
    add_order('{OP_MARKET, SIDE_SELL, '0, 24'd100000, '0});

    // random mix around a crossing spread
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(99);
      op = pick < 50 ? OP_PLACE : pick < 60 ? OP_MARKET : pick < 80 ? OP_CANCEL : OP_MODIFY;
      sd = 1'($urandom_range(1));
      pr = sd == SIDE_BUY ? $urandom_range(105, 95) : $urandom_range(110, 100);
      pick = $urandom_range(99);
      if (pick < 3) pr = '0;
      else if (pick < 7) pr = $urandom;
      qt = 24'($urandom_range(20, 1));
      pick = $urandom_range(99);
      if (pick < 4) qt = '0;
      else if (pick < 8) qt = 24'($urandom);
      add_order('{op, sd, pr, qt,
                  $urandom_range(99) < 85 ? gen_oid - $urandom_range(24, 1)
                                          : $urandom});
      if (op == OP_PLACE && pr != 0 && qt != 0) gen_oid++;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(n_accepted == pending_orders.size() && expected_reports.size() == 0)) begin
      @(posedge clk_i);
      if (cycles > LIMIT_CYCLES) begin
        $display("timeout after %0d cycles", cycles);
        $display("price_time_order_matcher_unit_tb failed");
        $finish;
      end
    end
    repeat (200) @(posedge clk_i);

    $display("covered %0d transactions, %0d results, %0d trades, %0d table-full summaries",
             n_accepted, n_results, n_trades, n_full);
    $display("mismatches: %0d, results still expected: %0d", errors, expected_reports.size());
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("price_time_order_matcher_unit_tb passed");
    end else begin
      $display("price_time_order_matcher_unit_tb failed");
    end
    $finish;
  end

endmodule

>>> price_time_order_matcher_unit.f
+incdir+design
design/pto_pkg.sv
design/pto_ram.sv
design/price_time_order_matcher_unit.sv
tb/price_time_order_matcher_unit_tb.sv
